// File: rtl/pcu_pkg.sv
// ---------------------------------------------------------------------------
// pcu_pkg
// Shared widths and types for the polygon centroid unit and its channels.
// ---------------------------------------------------------------------------
package pcu_pkg;

    localparam int DATA_W = 16;

    typedef logic signed [DATA_W-1:0] coord_t;

endpackage

// File: rtl/pcu_if.sv
// ---------------------------------------------------------------------------
// pcu_if
// Valid/ready channels of the polygon centroid unit: vertex beats in,
// centroid beats out.
// ---------------------------------------------------------------------------
interface pcu_vertex_if import pcu_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                    output ready);
endinterface

interface pcu_centroid_if import pcu_pkg::*;
();
    logic   valid;
    logic   ready;
    coord_t centroid_x;
    coord_t centroid_y;
    logic   degenerate;

    modport source (output valid, output centroid_x, output centroid_y, output degenerate,
                    input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, input degenerate,
                    output ready);
endinterface

// File: rtl/polygon_centroid_unit.sv
// ---------------------------------------------------------------------------
// polygon_centroid_unit
// Streaming shoelace centroid of a polygon on one shared multiplier and a
// restoring divider.
// ---------------------------------------------------------------------------
// Usage:
//   vertex   : one beat per vertex, last_vertex marks the closing vertex.
//   centroid : one beat per polygon, moment / (3 * area) per axis, truncated
//              toward zero and saturated to COORD_WIDTH bits, sign-extended.
// Sequence:
//   Each kept vertex beat after the first runs six steps after its accept
//   through the single multiplier (two cross products, subtract, two moment
//   products, final accumulate). The last vertex then needs a close step,
//   the closing edge (the same six steps), two setup steps and a bit-serial
//   division and saturate step per axis, then a step that loads the output
//   register; one or two vertices go from the close step to that last step,
//   a zero area from the first setup step. Vertices beyond MAX_VERTICES are
//   dropped; a dropped last vertex still closes the polygon.
// Reset: clears the sequencer, vertex count, sums and the output valid.
// Stall: the centroid sits in an output register; new vertices are taken
//   while it waits, and the next result holds until that beat is taken.
// ---------------------------------------------------------------------------
module polygon_centroid_unit import pcu_pkg::*;
#(
    parameter int MAX_VERTICES = 4096,
    parameter int COORD_WIDTH  = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    pcu_vertex_if.sink     vertex,
    pcu_centroid_if.source centroid
);

    localparam int CW = COORD_WIDTH;
    localparam int LW = $clog2(MAX_VERTICES);
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int SW = CW + 1;
    localparam int XW = 2 * CW + 1;
    localparam int PW = SW + XW;
    localparam int AW = XW + LW;
    localparam int MW = PW + LW;
    localparam int DW = AW + 2;
    localparam int RW = DW + CW + 1;
    localparam int QW = CW + 2;
    localparam int KW = $clog2(QW);

    localparam logic [NW-1:0] MAX_COUNT = NW'(MAX_VERTICES);
    localparam logic [CW:0]   Q_POS_LIM = (CW + 1)'((1 << (CW - 1)) - 1);
    localparam logic [CW:0]   Q_NEG_LIM = (CW + 1)'(1 << (CW - 1));
    localparam logic [CW-1:0] C_MAX     = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] C_MIN     = {1'b1, {(CW - 1){1'b0}}};

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_MUL_A  = 13'b0000000000010,
        S_MUL_B  = 13'b0000000000100,
        S_CROSS  = 13'b0000000001000,
        S_MOM_X  = 13'b0000000010000,
        S_MOM_Y  = 13'b0000000100000,
        S_ACC_Y  = 13'b0000001000000,
        S_CLOSE  = 13'b0000010000000,
        S_PREP   = 13'b0000100000000,
        S_LOAD   = 13'b0001000000000,
        S_DIV    = 13'b0010000000000,
        S_SAT    = 13'b0100000000000,
        S_RESULT = 13'b1000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [NW-1:0]         count_reg, count_next;
    logic signed [AW-1:0]  area_reg, area_next;
    logic signed [MW-1:0]  mx_reg, mx_next;
    logic signed [MW-1:0]  my_reg, my_next;
    logic                  closing_reg, closing_next;
    logic                  last_reg, last_next;
    logic                  axis_reg, axis_next;
    logic [KW-1:0]         cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;

    logic signed [CW-1:0]  first_x_reg, first_x_next;
    logic signed [CW-1:0]  first_y_reg, first_y_next;
    logic signed [CW-1:0]  prev_x_reg, prev_x_next;
    logic signed [CW-1:0]  prev_y_reg, prev_y_next;
    logic signed [CW-1:0]  cur_x_reg, cur_x_next;
    logic signed [CW-1:0]  cur_y_reg, cur_y_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [XW-1:0]  cross_reg, cross_next;
    logic signed [SW-1:0]  sx_reg, sx_next;
    logic signed [SW-1:0]  sy_reg, sy_next;
    logic [AW-1:0]         abs_reg, abs_next;
    logic [DW-1:0]         d_reg, d_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [RW-1:0]         dsh_reg, dsh_next;
    logic [QW-1:0]         q_reg, q_next;
    logic                  qneg_reg, qneg_next;
    logic signed [CW-1:0]  res_x_reg, res_x_next;
    logic signed [CW-1:0]  res_y_reg, res_y_next;
    logic                  res_degen_reg, res_degen_next;
    logic signed [CW-1:0]  out_x_reg, out_x_next;
    logic signed [CW-1:0]  out_y_reg, out_y_next;
    logic                  out_degen_reg, out_degen_next;

    logic signed [CW-1:0]  in_x, in_y;
    logic signed [CW-1:0]  edge_cx, edge_cy;
    logic signed [SW-1:0]  mul_a;
    logic signed [XW-1:0]  mul_b;
    logic signed [PW-1:0]  mul_prod;
    logic signed [SW-1:0]  mid_sx, mid_sy, mid_hx, mid_hy;
    logic [MW-1:0]         mag_mx, mag_my;
    logic [DW-1:0]         d3;
    logic                  div_ge;
    logic [CW:0]           q_low;
    logic [CW:0]           q_signed;
    logic                  q_ovf;
    logic signed [CW-1:0]  q_sat;
    logic                  accept;

    assign accept = vertex.valid && vertex.ready;
    assign in_x   = $signed(vertex.vertex_x[CW-1:0]);
    assign in_y   = $signed(vertex.vertex_y[CW-1:0]);

    assign edge_cx = closing_reg ? first_x_reg : cur_x_reg;
    assign edge_cy = closing_reg ? first_y_reg : cur_y_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MUL_A:
            begin
                mul_a = SW'(prev_x_reg);
                mul_b = XW'(edge_cy);
            end
            S_MUL_B:
            begin
                mul_a = SW'(edge_cx);
                mul_b = XW'(prev_y_reg);
            end
            S_MOM_X:
            begin
                mul_a = sx_reg;
                mul_b = cross_reg;
            end
            default:
            begin
                mul_a = sy_reg;
                mul_b = cross_reg;
            end
        endcase
    end

    assign mul_prod = PW'(mul_a) * PW'(mul_b);

    assign mid_sx = SW'(first_x_reg) + SW'(prev_x_reg);
    assign mid_sy = SW'(first_y_reg) + SW'(prev_y_reg);
    assign mid_hx = (mid_sx + SW'(mid_sx[SW-1])) >>> 1;
    assign mid_hy = (mid_sy + SW'(mid_sy[SW-1])) >>> 1;

    assign mag_mx = mx_reg[MW-1] ? MW'(-mx_reg) : MW'(mx_reg);
    assign mag_my = my_reg[MW-1] ? MW'(-my_reg) : MW'(my_reg);
    assign d3     = DW'(abs_reg) + (DW'(abs_reg) << 1);

    assign div_ge = rem_reg >= dsh_reg;

    assign q_low    = q_reg[QW-2:0];
    assign q_ovf    = q_reg[QW-1] || (qneg_reg ? (q_low > Q_NEG_LIM) : (q_low > Q_POS_LIM));
    assign q_signed = qneg_reg ? (CW + 1)'(-q_low) : q_low;
    assign q_sat    = q_ovf ? (qneg_reg ? C_MIN : C_MAX) : q_signed[CW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        area_next      = area_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        closing_next   = closing_reg;
        last_next      = last_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !centroid.ready;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        prod_next      = prod_reg;
        cross_next     = cross_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        abs_next       = abs_reg;
        d_next         = d_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        q_next         = q_reg;
        qneg_next      = qneg_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        res_degen_next = res_degen_reg;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_degen_next = out_degen_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cur_x_next   = in_x;
                    cur_y_next   = in_y;
                    last_next    = vertex.last_vertex;
                    closing_next = 1'b0;
                    if (count_reg == '0)
                    begin
                        first_x_next = in_x;
                        first_y_next = in_y;
                        prev_x_next  = in_x;
                        prev_y_next  = in_y;
                        count_next   = NW'(1);
                        state_next   = vertex.last_vertex ? S_CLOSE : S_IDLE;
                    end
                    else if (count_reg < MAX_COUNT)
                    begin
                        state_next = S_MUL_A;
                    end
                    else
                    begin
                        // drop
                        state_next = vertex.last_vertex ? S_CLOSE : S_IDLE;
                    end
                end
            end
            S_MUL_A:
            begin
                prod_next  = mul_prod;
                sx_next    = SW'(prev_x_reg) + SW'(edge_cx);
                sy_next    = SW'(prev_y_reg) + SW'(edge_cy);
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                prod_next  = mul_prod;
                cross_next = prod_reg[XW-1:0];
                state_next = S_CROSS;
            end
            S_CROSS:
            begin
                cross_next = cross_reg - prod_reg[XW-1:0];
                state_next = S_MOM_X;
            end
            S_MOM_X:
            begin
                prod_next  = mul_prod;
                area_next  = area_reg + AW'(cross_reg);
                state_next = S_MOM_Y;
            end
            S_MOM_Y:
            begin
                prod_next  = mul_prod;
                mx_next    = mx_reg + MW'(prod_reg);
                state_next = S_ACC_Y;
            end
            S_ACC_Y:
            begin
                my_next = my_reg + MW'(prod_reg);
                if (closing_reg)
                begin
                    state_next = S_PREP;
                end
                else
                begin
                    prev_x_next = cur_x_reg;
                    prev_y_next = cur_y_reg;
                    count_next  = count_reg + NW'(1);
                    state_next  = last_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                res_degen_next = 1'b0;
                if (count_reg == NW'(1))
                begin
                    res_x_next = first_x_reg;
                    res_y_next = first_y_reg;
                    state_next = S_RESULT;
                end
                else if (count_reg == NW'(2))
                begin
                    res_x_next = mid_hx[CW-1:0];
                    res_y_next = mid_hy[CW-1:0];
                    state_next = S_RESULT;
                end
                else
                begin
                    closing_next = 1'b1;
                    state_next   = S_MUL_A;
                end
            end
            S_PREP:
            begin
                if (area_reg == '0)
                begin
                    res_x_next     = '0;
                    res_y_next     = '0;
                    res_degen_next = 1'b1;
                    state_next     = S_RESULT;
                end
                else
                begin
                    abs_next   = area_reg[AW-1] ? AW'(-area_reg) : AW'(area_reg);
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                d_next     = d3;
                dsh_next   = RW'(d3) << (CW + 1);
                rem_next   = RW'(mag_mx);
                qneg_next  = mx_reg[MW-1] ^ area_reg[AW-1];
                q_next     = '0;
                cnt_next   = KW'(QW - 1);
                axis_next  = 1'b0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next   = {q_reg[QW-2:0], div_ge};
                dsh_next = dsh_reg >> 1;
                cnt_next = cnt_reg - KW'(1);
                if (cnt_reg == '0)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                if (!axis_reg)
                begin
                    res_x_next = q_sat;
                    axis_next  = 1'b1;
                    dsh_next   = RW'(d_reg) << (CW + 1);
                    rem_next   = RW'(mag_my);
                    qneg_next  = my_reg[MW-1] ^ area_reg[AW-1];
                    q_next     = '0;
                    cnt_next   = KW'(QW - 1);
                    state_next = S_DIV;
                end
                else
                begin
                    res_y_next = q_sat;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || centroid.ready)
                begin
                    out_x_next     = res_x_reg;
                    out_y_next     = res_y_reg;
                    out_degen_next = res_degen_reg;
                    out_valid_next = 1'b1;
                    count_next     = '0;
                    area_next      = '0;
                    mx_next        = '0;
                    my_next        = '0;
                    closing_next   = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            area_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            closing_reg   <= 1'b0;
            last_reg      <= 1'b0;
            axis_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            area_reg      <= area_next;
            mx_reg        <= mx_next;
            my_reg        <= my_next;
            closing_reg   <= closing_next;
            last_reg      <= last_next;
            axis_reg      <= axis_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg   <= first_x_next;
        first_y_reg   <= first_y_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        prod_reg      <= prod_next;
        cross_reg     <= cross_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        abs_reg       <= abs_next;
        d_reg         <= d_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        qneg_reg      <= qneg_next;
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        res_degen_reg <= res_degen_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_degen_reg <= out_degen_next;
    end

    assign vertex.ready        = (state_reg == S_IDLE);
    assign centroid.valid      = out_valid_reg;
    assign centroid.centroid_x = DATA_W'(out_x_reg);
    assign centroid.centroid_y = DATA_W'(out_y_reg);
    assign centroid.degenerate = out_degen_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_COUNT)
        else $error("vertex count beyond limit");

    a_sums_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && count_reg == '0) |->
        (area_reg == '0 && mx_reg == '0 && my_reg == '0))
        else $error("sums not cleared at polygon start");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (centroid.valid && centroid.degenerate) |->
        (centroid.centroid_x == '0 && centroid.centroid_y == '0))
        else $error("degenerate beat with nonzero centroid");

    a_beat_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_RESULT))
        else $error("centroid beat raised outside result step");

endmodule

// File: test/polygon_centroid_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// polygon_centroid_unit_test
// Self-checking bench for the streaming shoelace centroid unit. Vertex beats
// go in through a randomly idling source. Centroid beats come out through a
// randomly stalling sink. Each centroid beat is compared field by field with
// the oldest expected value: a table row's own, else an in-bench shoelace
// predictor's. A short table covers single points, midpoints, collinear and
// self-crossing outlines and the coordinate extremes. Random outlines follow.
// ---------------------------------------------------------------------------
module polygon_centroid_unit_test import pcu_pkg::*;
();

    localparam int     VERTEX_LIMIT  = 4096;
    localparam int     SHAPED_BEATS  = 1700;
    localparam int     DIRECTED_ROWS = 25;
    localparam int     DRAIN_CYCLES  = 100;
    localparam int     IDLE_PERCENT  = 38;
    localparam longint COORD_MAX     = 32767;
    localparam longint COORD_MIN     = -32768;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   degenerate;
    } centroid_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
        logic   typed;
        coord_t exp_x;
        coord_t exp_y;
        logic   exp_degenerate;
    } stimulus_row_t;

    typedef struct {
        coord_t             first_x;
        coord_t             first_y;
        coord_t             prev_x;
        coord_t             prev_y;
        logic [12:0]        count;
        logic signed [44:0] area;
        logic signed [61:0] moment_x;
        logic signed [61:0] moment_y;
    } shoelace_state_t;

    logic clk;
    logic rst_n;
    logic steady;

    pcu_vertex_if   vertex_ch ();
    pcu_centroid_if centroid_ch ();

    polygon_centroid_unit dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .vertex   (vertex_ch),
        .centroid (centroid_ch)
    );

    shoelace_state_t poly;
    centroid_t       expected_centroids [$];
    coord_t          outline_x [$];
    coord_t          outline_y [$];

    int vertex_beats;
    int centroid_beats;
    int polygon_count;
    int degenerate_count;
    int saturated_count;
    int dropped_vertices;
    int mismatch_count;

    stimulus_row_t directed_rows [DIRECTED_ROWS] = '{
        '{16'sh7fff, 16'sh8000, 1'b1, 1'b1, 16'sh7fff, 16'sh8000, 1'b0},
        '{16'sh8000, 16'sh7fff, 1'b1, 1'b1, 16'sh8000, 16'sh7fff, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 16'sh7fff, 16'sh7fff, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8001, 16'sh8001, 1'b1, 1'b1, 16'sh8001, 16'sh8001, 1'b0},
        '{16'shffff, 16'sh0001, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b1, 1'b1, 16'sh0000, 16'sh0000, 1'b1},
        '{16'sh0000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh0003, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh0000, 16'sh0003, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8000, 16'sh7fff, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sd1000, 16'sd2000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sd1000, -16'sd100, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{-16'sd300, -16'sd100, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{-16'sd300, 16'sd2000, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8000, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh7fff, 16'sh8000, 1'b0, 1'b0, 16'sh0000, 16'sh0000, 1'b0},
        '{16'sh8000, 16'sd32000, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 1'b0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(8_000_000);
        $display("%0t watchdog expired with %0d centroids outstanding", $time,
                 expected_centroids.size());
        $display("polygon_centroid_unit regression: fail");
        $finish;
    end

    function automatic void clear_outline_state();
        poly.first_x  = '0;
        poly.first_y  = '0;
        poly.prev_x   = '0;
        poly.prev_y   = '0;
        poly.count    = '0;
        poly.area     = '0;
        poly.moment_x = '0;
        poly.moment_y = '0;
    endfunction

    function automatic void accumulate_edge(coord_t px, coord_t py, coord_t cx, coord_t cy);
        longint cross_term;
        cross_term = longint'(px) * longint'(cy) - longint'(cx) * longint'(py);
        poly.area     = 45'(longint'(poly.area) + cross_term);
        poly.moment_x = 62'(longint'(poly.moment_x) + (longint'(px) + longint'(cx)) * cross_term);
        poly.moment_y = 62'(longint'(poly.moment_y) + (longint'(py) + longint'(cy)) * cross_term);
    endfunction

    function automatic coord_t clamp_coord(longint q);
        if (q > COORD_MAX)
            return coord_t'(COORD_MAX);
        if (q < COORD_MIN)
            return coord_t'(COORD_MIN);
        return coord_t'(q);
    endfunction

    // Fold one accepted vertex into the outline; return 1 when it closes one.
    function automatic logic fold_vertex(coord_t x, coord_t y, logic last,
                                         output centroid_t centroid);
        longint divisor;
        longint qx;
        longint qy;
        centroid = '0;
        if (int'(poly.count) < VERTEX_LIMIT)
        begin
            if (poly.count == 0)
            begin
                poly.first_x = x;
                poly.first_y = y;
            end
            else
                accumulate_edge(poly.prev_x, poly.prev_y, x, y);
            poly.prev_x = x;
            poly.prev_y = y;
            poly.count  = poly.count + 13'd1;
        end
        else
            dropped_vertices++;
        if (!last)
            return 1'b0;
        polygon_count++;
        if (poly.count == 1)
        begin
            centroid.x = poly.first_x;
            centroid.y = poly.first_y;
        end
        else if (poly.count == 2)
        begin
            centroid.x = coord_t'((longint'(poly.first_x) + longint'(poly.prev_x)) / 2);
            centroid.y = coord_t'((longint'(poly.first_y) + longint'(poly.prev_y)) / 2);
        end
        else
        begin
            accumulate_edge(poly.prev_x, poly.prev_y, poly.first_x, poly.first_y);
            if (poly.area == 0)
            begin
                centroid.degenerate = 1'b1;
                degenerate_count++;
            end
            else
            begin
                divisor = 3 * longint'(poly.area);
                qx = longint'(poly.moment_x) / divisor;
                qy = longint'(poly.moment_y) / divisor;
                if (qx > COORD_MAX || qx < COORD_MIN || qy > COORD_MAX || qy < COORD_MIN)
                    saturated_count++;
                centroid.x = clamp_coord(qx);
                centroid.y = clamp_coord(qy);
            end
        end
        clear_outline_state();
        return 1'b1;
    endfunction

    task automatic drive_vertex(coord_t x, coord_t y, logic last);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            vertex_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vertex_ch.valid       <= 1'b1;
        vertex_ch.vertex_x    <= x;
        vertex_ch.vertex_y    <= y;
        vertex_ch.last_vertex <= last;
        @(posedge clk);
        while (!vertex_ch.ready)
            @(posedge clk);
        vertex_beats++;
    endtask

    task automatic send_outline();
        centroid_t predicted;
        logic      last;
        for (int i = 0; i < outline_x.size(); i++)
        begin
            last = (i == outline_x.size() - 1);
            drive_vertex(outline_x[i], outline_y[i], last);
            if (fold_vertex(outline_x[i], outline_y[i], last, predicted))
                expected_centroids.push_back(predicted);
        end
    endtask

    function automatic void add_point(int x, int y);
        outline_x.push_back(coord_t'(x));
        outline_y.push_back(coord_t'(y));
    endfunction

    function automatic void add_noise_points(int n);
        for (int i = 0; i < n; i++)
        begin
            outline_x.push_back(coord_t'($urandom));
            outline_y.push_back(coord_t'($urandom));
        end
    endfunction

    function automatic void build_outline();
        int pick;
        int n;
        int base_x;
        int base_y;
        int step_x;
        int step_y;
        int span;
        int reach;
        int skew;
        pick = int'($urandom_range(99));
        outline_x.delete();
        outline_y.delete();
        if (pick < 8)
            add_noise_points(1);
        else if (pick < 18)
            add_noise_points(2);
        else if (pick < 28)
        begin
            n      = int'($urandom_range(8, 3));
            base_x = int'($urandom_range(2000)) - 1000;
            base_y = int'($urandom_range(2000)) - 1000;
            step_x = int'($urandom_range(100)) - 50;
            step_y = int'($urandom_range(100)) - 50;
            for (int k = 0; k < n; k++)
                add_point(base_x + k * step_x, base_y + k * step_y);
        end
        else if (pick < 38)
        begin
            reach = int'($urandom_range(32767, 10000));
            skew  = int'($urandom_range(2000));
            add_point(-reach, -reach);
            add_point(reach, reach);
            add_point(reach, -reach);
            add_point(-reach, reach - skew);
        end
        else if (pick < 52)
            add_noise_points(int'($urandom_range(10, 3)));
        else
        begin
            n      = int'($urandom_range(16, 3));
            base_x = int'($urandom_range(60000)) - 30000;
            base_y = int'($urandom_range(60000)) - 30000;
            span   = ($urandom_range(9) < 8) ? int'($urandom_range(255, 1))
                                             : int'($urandom_range(2700, 256));
            for (int k = 0; k < n; k++)
                add_point(base_x + int'($urandom_range(2 * span)) - span,
                          base_y + int'($urandom_range(2 * span)) - span);
        end
    endfunction

    task automatic flag_field(string field, longint want, longint seen);
        mismatch_count++;
        $display("%0t centroid %s mismatch: expected %0d, actual %0d", $time, field,
                 want, seen);
    endtask

    task automatic check_centroid();
        centroid_t want;
        if (expected_centroids.size() == 0)
        begin
            mismatch_count++;
            $display("%0t unexpected centroid beat: expected none, actual x=%0d y=%0d deg=%0b",
                     $time, centroid_ch.centroid_x, centroid_ch.centroid_y,
                     centroid_ch.degenerate);
            return;
        end
        want = expected_centroids.pop_front();
        centroid_beats++;
        if (centroid_ch.centroid_x !== want.x)
            flag_field("x", longint'(want.x), longint'(centroid_ch.centroid_x));
        if (centroid_ch.centroid_y !== want.y)
            flag_field("y", longint'(want.y), longint'(centroid_ch.centroid_y));
        if (centroid_ch.degenerate !== want.degenerate)
            flag_field("degenerate", longint'(want.degenerate),
                       longint'(centroid_ch.degenerate));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && centroid_ch.valid && centroid_ch.ready)
            check_centroid();
    end

    initial
    begin
        centroid_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            centroid_ch.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial
    begin
        stimulus_row_t row;
        centroid_t     predicted;
        int            shaped;
        rst_n                 = 1'b0;
        steady                = 1'b0;
        vertex_ch.valid       = 1'b0;
        vertex_ch.vertex_x    = '0;
        vertex_ch.vertex_y    = '0;
        vertex_ch.last_vertex = 1'b0;
        shaped                = 0;
        clear_outline_state();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            drive_vertex(row.x, row.y, row.last);
            if (fold_vertex(row.x, row.y, row.last, predicted))
            begin
                if (row.typed)
                    expected_centroids.push_back({row.exp_x, row.exp_y, row.exp_degenerate});
                else
                    expected_centroids.push_back(predicted);
            end
        end

        while (shaped < SHAPED_BEATS)
        begin
            steady = (shaped >= 300 && shaped < 700);
            build_outline();
            shaped += outline_x.size();
            send_outline();
        end
        steady = 1'b0;
        vertex_ch.valid <= 1'b0;

        while (expected_centroids.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d vertex beats in %0d polygons, %0d vertices past the limit.",
                 vertex_beats, polygon_count, dropped_vertices);
        $display("Checked %0d centroids: %0d degenerate, %0d saturated.",
                 centroid_beats, degenerate_count, saturated_count);
        if (mismatch_count == 0)
            $display("polygon_centroid_unit regression: pass");
        else
            $display("polygon_centroid_unit regression: fail");
        $finish;
    end

endmodule

// File: files.f
rtl/pcu_pkg.sv
rtl/pcu_if.sv
rtl/polygon_centroid_unit.sv
test/polygon_centroid_unit_test.sv
